[src/tts_pkg.sv]
// shared types and constants for the track torque split block
`default_nettype none

package tts_pkg;

	localparam int unsigned TORQUE_W = 32;
	localparam int unsigned SPEED_W  = 32;
	localparam int unsigned STEER_W  = 16;
	localparam int unsigned MB_W     = 12;
	localparam int unsigned BIAS_W   = 28;
	localparam int unsigned ALPHA_W  = 30;
	localparam int unsigned FACTOR_W = 17;
	localparam int unsigned CNT_W    = 5;
	localparam int unsigned IDX_W    = 2;

	// configuration register indexes
	localparam logic [IDX_W-1:0] CFG_BIAS_LIMIT = 2'd0;
	localparam logic [IDX_W-1:0] CFG_GYRATION   = 2'd1;
	localparam logic [IDX_W-1:0] CFG_CONNECTED  = 2'd2;

	localparam logic [MB_W-1:0]     BIAS_LIMIT_RST = 12'd512;
	localparam logic [MB_W-1:0]     BIAS_ONE       = 12'd256;
	localparam logic [SPEED_W-1:0]  DIFF_LOW       = 32'd16384;
	localparam logic [SPEED_W-1:0]  DIFF_HIGH      = 32'd32768;
	localparam logic [BIAS_W-1:0]   BIAS_UNITY     = 28'h100_0000;
	localparam logic signed [FACTOR_W-1:0] ONE_Q15 = 17'sd32768;

	typedef struct packed {
		logic signed [TORQUE_W-1:0] drive_torque;
		logic signed [SPEED_W-1:0]  left_speed;
		logic signed [SPEED_W-1:0]  right_speed;
		logic signed [STEER_W-1:0]  steer;
	} in_item_t;

	typedef struct packed {
		logic signed [TORQUE_W-1:0] left_torque;
		logic signed [TORQUE_W-1:0] right_torque;
		logic signed [SPEED_W-1:0]  shaft_speed;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_BIAS,
		ST_DIV,
		ST_MUL,
		ST_ROUND,
		ST_SPLIT,
		ST_SCALE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic diff_ld;
		logic bias_ld;
		logic div_step;
		logic mul_ld;
		logic rnd_ld;
		logic split_ld;
		logic scale_ld;
		logic out_ld;
	} dp_cmd_t;

	typedef struct packed {
		logic div_last;
	} dp_sts_t;

endpackage

`default_nettype wire

[src/tts_ctrl.sv]
// control state machine for the torque split datapath
`default_nettype none

module tts_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	input  wire tts_pkg::dp_sts_t  sts,
	output tts_pkg::dp_cmd_t       cmd
);

	tts_pkg::state_t state_q, state_nxt;
	logic out_valid_q;
	logic out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tts_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		unique case (state_q)
			tts_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = tts_pkg::ST_DIFF;
				end
			end
			tts_pkg::ST_DIFF: begin
				cmd.diff_ld = 1'b1;
				state_nxt   = tts_pkg::ST_BIAS;
			end
			tts_pkg::ST_BIAS: begin
				cmd.bias_ld = 1'b1;
				state_nxt   = tts_pkg::ST_DIV;
			end
			tts_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_nxt = tts_pkg::ST_MUL;
				end
			end
			tts_pkg::ST_MUL: begin
				cmd.mul_ld = 1'b1;
				state_nxt  = tts_pkg::ST_ROUND;
			end
			tts_pkg::ST_ROUND: begin
				cmd.rnd_ld = 1'b1;
				state_nxt  = tts_pkg::ST_SPLIT;
			end
			tts_pkg::ST_SPLIT: begin
				cmd.split_ld = 1'b1;
				state_nxt    = tts_pkg::ST_SCALE;
			end
			tts_pkg::ST_SCALE: begin
				cmd.scale_ld = 1'b1;
				state_nxt    = tts_pkg::ST_DONE;
			end
			tts_pkg::ST_DONE: begin
				// wait until the previous result has left the output register
				if (out_free) begin
					cmd.out_ld = 1'b1;
					state_nxt  = tts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = tts_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[src/tts_dp.sv]
// datapath: speed difference, bias, bias share divider, split and steering scale
`default_nettype none

module tts_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire tts_pkg::in_item_t            in_data,
	input  wire logic [tts_pkg::MB_W-1:0]     bias_limit,
	input  wire logic                         gyration_mode,
	input  wire logic                         connected,
	input  wire tts_pkg::dp_cmd_t             cmd,
	output tts_pkg::dp_sts_t                  sts,
	output tts_pkg::out_item_t                out_data
);

	localparam int unsigned TW = tts_pkg::TORQUE_W;
	localparam int unsigned SW = tts_pkg::SPEED_W;
	localparam int unsigned AW = tts_pkg::ALPHA_W;
	localparam int unsigned BW = tts_pkg::BIAS_W;
	localparam int unsigned FW = tts_pkg::FACTOR_W;
	localparam int unsigned PW = TW + AW + 1;
	localparam int unsigned QW = TW + 1 + FW;

	function automatic logic signed [TW-1:0] sat32(input logic signed [QW-16:0] v);
		logic signed [TW-1:0] r;
		if (v[QW-16:TW-1] == '0 || v[QW-16:TW-1] == '1) begin
			r = v[TW-1:0];
		end else if (v[QW-16]) begin
			r = {1'b1, {(TW-1){1'b0}}};
		end else begin
			r = {1'b0, {(TW-1){1'b1}}};
		end
		return r;
	endfunction

	// captured transaction
	logic signed [TW-1:0] torque_q;
	logic signed [SW-1:0] ls_q, rs_q;
	logic signed [tts_pkg::STEER_W-1:0] steer_q;

	// speed stage
	logic [SW-1:0] diff_q;
	logic signed [SW-1:0] speed_q;
	logic left_slow_q;

	// divider
	logic [BW:0] rem_q, den_q;
	logic [AW-1:0] quo_q;
	logic [tts_pkg::CNT_W-1:0] cnt_q;

	logic signed [PW-1:0] prod_q;
	logic signed [TW-1:0] slow_q;
	logic signed [TW:0] tl_q, tr_q;
	logic signed [FW-1:0] fl_q, fr_q;
	logic signed [QW-1:0] pl_q, pr_q;
	logic signed [SW-1:0] held_q;
	tts_pkg::out_item_t out_q;

	// speed stage logic
	logic signed [SW:0] ls_x, rs_x, d_wide, s_wide, nd, nl, nr;
	logic [SW-1:0] abs_d, abs_l, abs_r;

	assign ls_x   = {ls_q[SW-1], ls_q};
	assign rs_x   = {rs_q[SW-1], rs_q};
	assign d_wide = ls_x - rs_x;
	assign s_wide = ls_x + rs_x + (SW+1)'(1);
	assign nd     = -d_wide;
	assign nl     = -ls_x;
	assign nr     = -rs_x;
	assign abs_d  = d_wide[SW] ? nd[SW-1:0] : d_wide[SW-1:0];
	assign abs_l  = ls_q[SW-1] ? nl[SW-1:0] : ls_q;
	assign abs_r  = rs_q[SW-1] ? nr[SW-1:0] : rs_q;

	// bias stage logic
	logic [tts_pkg::MB_W-1:0] mb, mb_ex;
	logic [BW-1:0] lin_prod;
	logic [BW+1:0] lin_sum;
	logic [BW-1:0] bias;

	assign mb       = (bias_limit < tts_pkg::BIAS_ONE) ? tts_pkg::BIAS_ONE : bias_limit;
	assign mb_ex    = mb - tts_pkg::BIAS_ONE;
	assign lin_prod = BW'(mb_ex) * BW'(diff_q[15:0]);
	// two times the unit bias minus the bias limit, plus the slope term
	assign lin_sum  = {lin_prod, 2'b00} + (BW+2)'({tts_pkg::BIAS_UNITY, 1'b0})
		- (BW+2)'({mb, 16'h0000});

	always_comb begin
		if (diff_q > tts_pkg::DIFF_HIGH) begin
			bias = {mb, 16'h0000};
		end else if (diff_q > tts_pkg::DIFF_LOW) begin
			bias = lin_sum[BW-1:0];
		end else begin
			bias = tts_pkg::BIAS_UNITY;
		end
	end

	// restoring divider step, remainder always below the divisor
	logic [BW+1:0] r2, r2_sub;
	logic r_ge;

	assign r2     = {rem_q, 1'b0};
	assign r2_sub = r2 - {1'b0, den_q};
	assign r_ge   = r2 >= {1'b0, den_q};

	assign sts.div_last = (cnt_q == tts_pkg::CNT_W'(AW - 1));

	logic signed [AW:0] alpha_s;
	logic signed [PW-1:0] rnd;
	assign alpha_s = {1'b0, quo_q};
	assign rnd     = prod_q + PW'(64'sd1 <<< (AW - 1));

	// split and steering factor logic
	logic signed [TW:0] slow_x, fast_x;
	logic signed [FW-1:0] gs, fl, fr;

	assign slow_x = {slow_q[TW-1], slow_q};
	assign fast_x = {torque_q[TW-1], torque_q} - slow_x;
	assign gs     = gyration_mode ? {steer_q, 1'b0} : {steer_q[tts_pkg::STEER_W-1], steer_q};
	assign fl     = (steer_q > 16'sd0) ? tts_pkg::ONE_Q15 - gs : tts_pkg::ONE_Q15;
	assign fr     = (steer_q < 16'sd0) ? tts_pkg::ONE_Q15 + gs : tts_pkg::ONE_Q15;

	logic signed [QW-1:0] rl, rr;
	assign rl = pl_q + QW'(16384);
	assign rr = pr_q + QW'(16384);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			torque_q <= in_data.drive_torque;
			ls_q     <= in_data.left_speed;
			rs_q     <= in_data.right_speed;
			steer_q  <= in_data.steer;
		end
		if (cmd.diff_ld) begin
			diff_q      <= abs_d;
			speed_q     <= s_wide[SW:1];
			left_slow_q <= abs_l < abs_r;
		end
		if (cmd.bias_ld) begin
			rem_q <= {1'b0, bias};
			den_q <= {1'b0, bias} + (BW+1)'(tts_pkg::BIAS_UNITY);
			quo_q <= '0;
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= r_ge ? r2_sub[BW:0] : r2[BW:0];
			quo_q <= {quo_q[AW-2:0], r_ge};
			cnt_q <= cnt_q + tts_pkg::CNT_W'(1);
		end
		if (cmd.mul_ld) begin
			prod_q <= PW'(torque_q) * PW'(alpha_s);
		end
		if (cmd.rnd_ld) begin
			slow_q <= rnd[AW+TW-1:AW];
		end
		if (cmd.split_ld) begin
			tl_q <= left_slow_q ? slow_x : fast_x;
			tr_q <= left_slow_q ? fast_x : slow_x;
			fl_q <= fl;
			fr_q <= fr;
		end
		if (cmd.scale_ld) begin
			pl_q <= QW'(tl_q) * QW'(fl_q);
			pr_q <= QW'(tr_q) * QW'(fr_q);
		end
		if (cmd.out_ld) begin
			if (connected) begin
				out_q.left_torque  <= sat32(rl[QW-1:15]);
				out_q.right_torque <= sat32(rr[QW-1:15]);
				out_q.shaft_speed  <= speed_q;
			end else begin
				out_q.left_torque  <= '0;
				out_q.right_torque <= '0;
				out_q.shaft_speed  <= held_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (cmd.out_ld && connected) begin
			held_q <= speed_q;
		end
	end

	assign out_data = out_q;

endmodule

`default_nettype wire

[src/track_torque_split_differential.sv]
// one transaction at a time: the input stalls from capture until the result is loaded
// into the output register, and a stalled output also holds the input off
// the 30-iteration restoring divider for the slow-side share takes most of each transaction
// a new input is taken while a finished result waits in the output register
// reset: control idle, output empty, config to defaults, held shaft speed zero
`default_nettype none

module track_torque_split_differential (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire tts_pkg::in_item_t             in_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output tts_pkg::out_item_t                 out_data,
	input  wire logic                          cfg_we,
	input  wire logic [tts_pkg::IDX_W-1:0]     cfg_index,
	input  wire logic [tts_pkg::MB_W-1:0]      cfg_data
);

	logic [tts_pkg::MB_W-1:0] bias_limit_q;
	logic gyration_q;
	logic connected_q;

	tts_pkg::dp_cmd_t cmd;
	tts_pkg::dp_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_limit_q <= tts_pkg::BIAS_LIMIT_RST;
			gyration_q   <= 1'b0;
			connected_q  <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tts_pkg::CFG_BIAS_LIMIT: bias_limit_q <= cfg_data;
				tts_pkg::CFG_GYRATION:   gyration_q   <= cfg_data[0];
				tts_pkg::CFG_CONNECTED:  connected_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	tts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tts_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_data       (in_data),
		.bias_limit    (bias_limit_q),
		.gyration_mode (gyration_q),
		.connected     (connected_q),
		.cmd           (cmd),
		.sts           (sts),
		.out_data      (out_data)
	);

endmodule

`default_nettype wire

[src/tts_checker.sv]
// port-level checks for the track torque split block
`default_nettype none

module tts_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_stall,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire tts_pkg::out_item_t  out_data
);

	// one transaction at a time: busy right after taking one
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while busy");

	// a result never appears the cycle after an input is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !$rose(out_valid))
		else $error("result too early");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(out_data))
		else $error("stalled result changed");

endmodule

bind track_torque_split_differential tts_checker u_tts_checker (.*);

`default_nettype wire

[tb/tb_track_torque_split_differential.sv]
// self-checking testbench for the track torque split block: random and directed samples
`timescale 1ns / 100ps

module tb_track_torque_split_differential;
	import tts_pkg::*;

	localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int LONG_HOLD = 400;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	in_item_t            in_data = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	out_item_t           out_data;
	logic                cfg_we = 1'b0;
	logic [IDX_W-1:0]    cfg_index = CFG_BIAS_LIMIT;
	logic [MB_W-1:0]     cfg_data = '0;

	// shadow of the block's registers and held speed
	logic [MB_W-1:0]     bias_cap = BIAS_LIMIT_RST;
	logic                steer_x2 = 1'b0;
	logic                link_on = 1'b1;
	logic signed [31:0]  held_speed = '0;

	in_item_t            pending_samples[$];
	out_item_t           torque_splits[$];
	out_item_t           split_want;

	int                  fails = 0;
	logic                idle_on = 1'b1;
	int                  send_gap = 0;
	int                  stall_left = 0;
	int                  hold_req = 0;
	int                  hold_seen = 0;
	int                  hold_left = 0;

	track_torque_split_differential dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic longint round_q(input longint v, input int k);
		return (v + (longint'(1) <<< (k - 1))) >>> k;
	endfunction

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic out_item_t predict_split(input in_item_t s);
		out_item_t r;
		longint tq, ls, rs, st, mean, diff, mb, bias, alpha;
		longint slow, fast, tl, tr, gain, fl, fr, als, ars;
		tq = longint'(s.drive_torque);
		ls = longint'(s.left_speed);
		rs = longint'(s.right_speed);
		st = longint'(s.steer);
		if (!link_on) begin
			r.left_torque = '0;
			r.right_torque = '0;
			r.shaft_speed = held_speed;
			return r;
		end
		mean = (ls + rs + 1) >>> 1;
		held_speed = mean[31:0];
		mb = (bias_cap < BIAS_ONE) ? longint'(BIAS_ONE) : longint'(bias_cap);
		diff = (ls > rs) ? ls - rs : rs - ls;
		// bias in Q4.24, linear ramp between the two difference thresholds
		if (diff > longint'(DIFF_HIGH))
			bias = mb <<< 16;
		else if (diff > longint'(DIFF_LOW))
			bias = 4 * (mb - longint'(BIAS_ONE)) * diff + ((2 * longint'(BIAS_ONE) - mb) <<< 16);
		else
			bias = longint'(BIAS_UNITY);
		alpha = (bias <<< 30) / (bias + longint'(BIAS_UNITY));
		slow = round_q(tq * alpha, 30);
		fast = tq - slow;
		als = (ls < 0) ? -ls : ls;
		ars = (rs < 0) ? -rs : rs;
		if (als < ars) begin
			tl = slow;
			tr = fast;
		end else begin
			tl = fast;
			tr = slow;
		end
		gain = steer_x2 ? 2 : 1;
		fl = longint'(ONE_Q15);
		fr = longint'(ONE_Q15);
		if (st > 0)
			fl = longint'(ONE_Q15) - gain * st;
		if (st < 0)
			fr = longint'(ONE_Q15) + gain * st;
		r.left_torque = clamp32(round_q(tl * fl, 15));
		r.right_torque = clamp32(round_q(tr * fr, 15));
		r.shaft_speed = held_speed;
		return r;
	endfunction

	function automatic in_item_t random_sample();
		in_item_t s;
		logic signed [31:0] delta;
		int pick;
		s.drive_torque = $urandom;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			s.drive_torque = 32'sh7FFF_FFFF;
		else if (pick == 1)
			s.drive_torque = 32'sh8000_0000;
		else if (pick < 4)
			s.drive_torque = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
		case ($urandom_range(0, 5))
			0: s.left_speed = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			1, 2: s.left_speed = $urandom;
			default: s.left_speed = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
		endcase
		// steer the speed difference around the bias ramp most of the time
		case ($urandom_range(0, 7))
			0: delta = '0;
			1: delta = ($urandom_range(0, 1) ? 32'sd16384 : 32'sd32768) + $urandom_range(0, 2) - 1;
			2, 3: delta = $urandom_range(16384, 32768);
			4: delta = $urandom_range(0, 16384);
			5: delta = $urandom_range(32768, 32'h0010_0000);
			default: delta = $urandom;
		endcase
		if ($urandom_range(0, 1))
			delta = -delta;
		if ($urandom_range(0, 15) == 0)
			s.right_speed = -s.left_speed;
		else
			s.right_speed = s.left_speed + delta;
		case ($urandom_range(0, 7))
			0: s.steer = 16'sh7FFF;
			1: s.steer = 16'sh8000;
			2: s.steer = '0;
			default: s.steer = STEER_W'($urandom);
		endcase
		return s;
	endfunction

	task automatic push_sample(input logic [31:0] t, input logic [31:0] l,
			input logic [31:0] r, input logic [15:0] st);
		in_item_t s;
		s.drive_torque = t;
		s.left_speed = l;
		s.right_speed = r;
		s.steer = st;
		pending_samples.push_back(s);
	endtask

	task automatic push_random(input int n);
		repeat (n) pending_samples.push_back(random_sample());
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [MB_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_BIAS_LIMIT: bias_cap = val;
			CFG_GYRATION: steer_x2 = val[0];
			CFG_CONNECTED: link_on = val[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (pending_samples.size() != 0 || in_valid || torque_splits.size() != 0);
	endtask

	// sender: valid and payload hold while stalled
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				torque_splits.push_back(predict_split(in_data));
			if (!in_valid || !in_stall) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (idle_on && pending_samples.size() != 0 &&
						$urandom_range(0, 5) == 0) begin
					send_gap <= $urandom_range(0, 13);
					in_valid <= 1'b0;
				end else if (pending_samples.size() != 0) begin
					in_valid <= 1'b1;
					in_data <= pending_samples.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: short random stalls plus the long hold on request
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_seen != hold_req) begin
				hold_seen <= hold_req;
				hold_left <= LONG_HOLD;
				out_stall <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left <= $urandom_range(0, 13);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (torque_splits.size() == 0) begin
				if (fails < 10)
					$display("unexpected transaction: %h", out_data);
				fails = fails + 1;
			end else begin
				split_want = torque_splits.pop_front();
				if (out_data.left_torque !== split_want.left_torque ||
						out_data.right_torque !== split_want.right_torque ||
						out_data.shaft_speed !== split_want.shaft_speed) begin
					if (fails < 10)
						$display("mismatch (exp/got): left %0d/%0d right %0d/%0d speed %0d/%0d",
							split_want.left_torque, out_data.left_torque,
							split_want.right_torque, out_data.right_torque,
							split_want.shaft_speed, out_data.shaft_speed);
					fails = fails + 1;
				end
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: zero, equal speeds, ramp edges, extreme speeds, equal magnitudes
		push_sample(32'h0, 32'h0, 32'h0, 16'h0);
		push_sample(32'h7FFF_FFFF, 32'h0001_0000, 32'h0001_0000, 16'h0);
		push_sample(32'h8000_0000, 32'h0, 32'd16384, 16'h7FFF);
		push_sample(32'h1234_5678, 32'h0, 32'd16385, 16'h8000);
		push_sample(-32'sd65536, 32'd100000, 32'd132768, 16'h0001);
		push_sample(32'h4000_0000, 32'd5000, 32'd5000 - 32'd32769, 16'hFFFF);
		push_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0);
		push_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8000);
		push_sample(32'hFFFF_FFFF, 32'd200000, -32'sd200000, 16'h4000);
		push_sample(32'd3, 32'd1000, 32'd25000, 16'h7FFF);
		push_sample(-32'sd3, -32'sd30000, 32'h0, 16'h8000);
		wait_idle();
		push_random(150);
		wait_idle();

		write_reg(CFG_BIAS_LIMIT, 12'd4095);
		write_reg(CFG_GYRATION, 12'd1);
		@(negedge clk);
		push_sample(32'h7FFF_FFFF, 32'h0, 32'd24576, 16'h7FFF);
		push_sample(32'h8000_0000, 32'h0, 32'd24576, 16'h8000);
		push_sample(32'h8000_0000, 32'h0, 32'd40000, 16'h8000);
		// output held off while the sender keeps offering, so the input backs up
		hold_req = hold_req + 1;
		push_random(150);
		wait_idle();

		// bias cap below one, no idling on either side
		idle_on = 1'b0;
		write_reg(CFG_BIAS_LIMIT, 12'd0);
		write_reg(CFG_GYRATION, 12'hFFE);
		@(negedge clk);
		push_sample(32'h7FFF_FFFF, 32'h0, 32'd50000, 16'h1234);
		push_sample(32'd1000, -32'sd20000, 32'h0, 16'hEDCC);
		push_random(100);
		wait_idle();

		idle_on = 1'b1;
		write_reg(CFG_BIAS_LIMIT, 12'd255);
		@(negedge clk);
		push_sample(32'h7FFF_FFFF, 32'h0, 32'd30000, 16'h0);
		wait_idle();
		write_reg(CFG_CONNECTED, 12'hFFE);
		@(negedge clk);
		push_sample(32'd12345, 32'd999, 32'd777, 16'd100);
		push_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF);
		push_random(60);
		wait_idle();
		write_reg(CFG_CONNECTED, 12'h801);
		write_reg(CFG_UNUSED, 12'hABC);
		@(negedge clk);
		push_sample(32'd5, 32'd6, 32'd7, 16'd8);
		hold_req = hold_req + 1;
		push_random(100);
		wait_idle();

		for (int k = 0; k < 4; k++) begin
			write_reg(CFG_BIAS_LIMIT, (k == 0) ? BIAS_ONE : MB_W'($urandom_range(0, 4095)));
			write_reg(CFG_GYRATION, MB_W'($urandom_range(0, 4095)));
			write_reg(CFG_CONNECTED, ($urandom_range(0, 3) == 0) ? 12'd0 : 12'd1);
			@(negedge clk);
			push_random(100);
			wait_idle();
		end

		idle_on = 1'b0;
		write_reg(CFG_BIAS_LIMIT, 12'd1000);
		write_reg(CFG_GYRATION, 12'd1);
		write_reg(CFG_CONNECTED, 12'd1);
		@(negedge clk);
		push_random(150);
		wait_idle();

		repeat (60) @(posedge clk);
		@(negedge clk);
		if (torque_splits.size() != 0)
			fails = fails + 1;
		if (fails == 0)
			$display("tb_track_torque_split_differential: PASS");
		else
			$display("tb_track_torque_split_differential: FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_track_torque_split_differential: FAIL");
		$finish;
	end

endmodule
